@@ hdl/sbsi_pkg.sv @@
// shared types and constants for the segment versus box slab test
package sbsi_pkg;

   localparam int COORD_FRAC_BITS = 16;
   localparam int AXES            = 3;
   localparam int COORD_W         = 32;
   localparam int SIZE_W          = 31;
   localparam int DIR_W           = COORD_W + 1;
   localparam int BOUND_W         = COORD_W + 1;
   localparam int NUM_W           = BOUND_W + 1;
   localparam int NMAG_W          = NUM_W + COORD_FRAC_BITS;
   localparam int DIV_W           = NMAG_W + 1;
   localparam int Q_W             = COORD_FRAC_BITS + 1;
   localparam int T_W             = Q_W + 2;
   localparam int PROD_W          = DIR_W + Q_W + 1;
   localparam int IDX_W           = 3;
   localparam int QDEPTH          = 4;
   localparam int QPTR_W          = 2;
   localparam int QCNT_W          = 3;

   localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd0;
   localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd1;
   localparam logic [IDX_W-1:0] REG_CENTER_Z = 3'd2;
   localparam logic [IDX_W-1:0] REG_SIZE_X   = 3'd3;
   localparam logic [IDX_W-1:0] REG_SIZE_Y   = 3'd4;
   localparam logic [IDX_W-1:0] REG_SIZE_Z   = 3'd5;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] start_z;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] end_z;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } rsp_type;

   typedef struct packed {
      logic signed [BOUND_W-1:0] lo;
      logic signed [BOUND_W-1:0] hi;
   } bound_type;

   typedef bound_type [AXES-1:0] bound_set_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] start;
      logic signed [DIR_W-1:0]   dir;
      logic signed [NUM_W-1:0]   num_lo;
      logic signed [NUM_W-1:0]   num_hi;
   } slab_type;

   typedef slab_type [AXES-1:0] slab_set_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ hdl/segment_box_slab_intersection.sv @@
// top level: segment versus axis-aligned box, slab method, Q16.16
// One segment transfer is taken per clock while req_stall is low, and one result transfer comes
// out per segment, in order. From an accepted segment to its result the path is a queue write,
// one stage for magnitudes, one for the quotient range check, 17 restoring division stages (one
// quotient bit each, six dividers side by side), then interval ordering, the slab merge, the
// direction-times-tmin multiply and the output register. A stall on the result side freezes the
// back-end pipe; the four-entry queue absorbs the front end until it fills, and only then is
// req_stall raised. Box registers are written through the csr port (centers at index 0 to 2,
// sizes at 3 to 5, other indexes ignored); writing them only while no segment is in flight is
// up to the user, not enforced here; the slab bounds update in the cycle after a write.
module segment_box_slab_intersection (
   input  logic                         clock,
   input  logic                         reset,
   // segment transfers
   input  logic                         req_valid,
   output logic                         req_stall,
   input  sbsi_pkg::req_type            req_data,
   // result transfers
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output sbsi_pkg::rsp_type            rsp_data,
   // box configuration writes
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [sbsi_pkg::IDX_W-1:0]   csr_index,
   input  logic [sbsi_pkg::COORD_W-1:0] csr_data
);
   import sbsi_pkg::*;

   bound_set_type    bounds;
   queue_status_type qstat;
   slab_set_type     push_data, head;
   logic             push, pop;

   // box registers, bounds held as center minus / plus floor half size
   sbsi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .bounds    (bounds)
   );

   // front: direction and bound-minus-start per axis
   sbsi_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .bounds    (bounds),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   // decoupling queue
   sbsi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   // back: divisions, merge, entry point
   sbsi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hdl/sbsi_csr.sv @@
// box configuration registers and registered slab bounds
module sbsi_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sbsi_pkg::IDX_W-1:0]     csr_index,
   input  logic [sbsi_pkg::COORD_W-1:0]   csr_data,
   output sbsi_pkg::bound_set_type        bounds
);
   import sbsi_pkg::*;

   logic signed [COORD_W-1:0] center_ff [AXES];
   logic [SIZE_W-1:0]         size_ff [AXES];
   bound_set_type             bounds_ff, bounds_in;

   assign csr_ready = 1'b1;
   assign bounds    = bounds_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            center_ff[i] <= '0;
            size_ff[i]   <= '0;
         end
      end else if (csr_valid) begin
         case (csr_index)
            REG_CENTER_X: center_ff[0] <= csr_data;
            REG_CENTER_Y: center_ff[1] <= csr_data;
            REG_CENTER_Z: center_ff[2] <= csr_data;
            REG_SIZE_X:   size_ff[0]   <= csr_data[SIZE_W-1:0];
            REG_SIZE_Y:   size_ff[1]   <= csr_data[SIZE_W-1:0];
            REG_SIZE_Z:   size_ff[2]   <= csr_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // floor halving of the extent, then center minus / plus half
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         bounds_in[i].lo = BOUND_W'(center_ff[i])
                           - $signed(BOUND_W'(size_ff[i] >> 1));
         bounds_in[i].hi = BOUND_W'(center_ff[i])
                           + $signed(BOUND_W'(size_ff[i] >> 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bounds_ff <= '0;
      end else begin
         bounds_ff <= bounds_in;
      end
   end

endmodule

@@ hdl/sbsi_front.sv @@
// front end: takes a segment and forms direction and slab numerators
module sbsi_front (
   input  logic                       req_valid,
   output logic                       req_stall,
   input  sbsi_pkg::req_type          req_data,
   input  sbsi_pkg::bound_set_type    bounds,
   input  sbsi_pkg::queue_status_type qstat,
   output logic                       push,
   output sbsi_pkg::slab_set_type     push_data
);
   import sbsi_pkg::*;

   logic signed [COORD_W-1:0] start_v [AXES];
   logic signed [COORD_W-1:0] end_v [AXES];

   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full;

   always_comb begin
      start_v[0] = req_data.start_x;
      start_v[1] = req_data.start_y;
      start_v[2] = req_data.start_z;
      end_v[0]   = req_data.end_x;
      end_v[1]   = req_data.end_y;
      end_v[2]   = req_data.end_z;
      for (int i = 0; i < AXES; i++) begin
         push_data[i].start  = start_v[i];
         push_data[i].dir    = DIR_W'(end_v[i]) - DIR_W'(start_v[i]);
         push_data[i].num_lo = NUM_W'(bounds[i].lo) - NUM_W'(start_v[i]);
         push_data[i].num_hi = NUM_W'(bounds[i].hi) - NUM_W'(start_v[i]);
      end
   end

endmodule

@@ hdl/sbsi_queue.sv @@
// short queue between front end and back end
module sbsi_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  sbsi_pkg::slab_set_type     push_data,
   input  logic                       pop,
   output sbsi_pkg::slab_set_type     head,
   output sbsi_pkg::queue_status_type qstat
);
   import sbsi_pkg::*;

   slab_set_type       mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;

   assign head        = mem_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == QCNT_W'(QDEPTH));
   assign qstat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ hdl/sbsi_back.sv @@
// back end: pipelined slab divisions, interval merge, entry point
module sbsi_back (
   input  logic                       clock,
   input  logic                       reset,
   input  sbsi_pkg::slab_set_type     head,
   input  sbsi_pkg::queue_status_type qstat,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output sbsi_pkg::rsp_type          rsp_data
);
   import sbsi_pkg::*;

   typedef struct packed {
      logic signed [COORD_W-1:0] start;
      logic signed [DIR_W-1:0]   dir;
      logic                      par;
      logic                      in_slab;
      logic [DIR_W-1:0]          dmag;
      logic [1:0]                qneg;
      logic [1:0]                sat;
      logic [1:0][DIV_W-1:0]     rem;
      logic [1:0][Q_W-1:0]       quo;
   } div_axis_type;

   typedef div_axis_type [AXES-1:0] div_set_type;

   logic                      en;
   div_set_type               a_ff, a_in;
   logic                      a_v_ff;
   div_set_type               dv_ff [Q_W+1];
   div_set_type               dv_in [Q_W+1];
   logic                      dv_v_ff [Q_W+1];
   logic signed [T_W-1:0]     tlo_ff [AXES], tlo_in [AXES];
   logic signed [T_W-1:0]     thi_ff [AXES], thi_in [AXES];
   logic signed [COORD_W-1:0] t_start_ff [AXES];
   logic signed [DIR_W-1:0]   t_dir_ff [AXES];
   logic                      t_ok_ff, t_ok_in, t_v_ff;
   logic [Q_W-1:0]            tmin_ff, tmin_in;
   logic                      c_hit_ff, c_hit_in, c_v_ff;
   logic signed [COORD_W-1:0] c_start_ff [AXES];
   logic signed [DIR_W-1:0]   c_dir_ff [AXES];
   logic signed [PROD_W-1:0]  prod_ff [AXES];
   logic signed [COORD_W-1:0] m_start_ff [AXES];
   logic                      m_hit_ff, m_v_ff;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_v_ff;

   // whole pipe moves together whenever the output slot frees up
   assign en        = !rsp_v_ff || !rsp_stall;
   assign pop       = en && !qstat.empty;
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   // magnitudes and signs for the signed divisions
   always_comb begin
      logic [NUM_W-1:0] nm;
      for (int i = 0; i < AXES; i++) begin
         a_in[i]         = '0;
         a_in[i].start   = head[i].start;
         a_in[i].dir     = head[i].dir;
         a_in[i].par     = (head[i].dir == '0);
         a_in[i].in_slab = (head[i].num_lo <= 0) && (head[i].num_hi >= 0);
         a_in[i].dmag   = head[i].dir[DIR_W-1] ? DIR_W'(-head[i].dir)
                                                : DIR_W'(head[i].dir);
         nm = head[i].num_lo[NUM_W-1] ? NUM_W'(-head[i].num_lo)
                                      : NUM_W'(head[i].num_lo);
         a_in[i].rem[0]  = DIV_W'(nm) << COORD_FRAC_BITS;
         a_in[i].qneg[0] = head[i].num_lo[NUM_W-1] ^ head[i].dir[DIR_W-1];
         nm = head[i].num_hi[NUM_W-1] ? NUM_W'(-head[i].num_hi)
                                      : NUM_W'(head[i].num_hi);
         a_in[i].rem[1]  = DIV_W'(nm) << COORD_FRAC_BITS;
         a_in[i].qneg[1] = head[i].num_hi[NUM_W-1] ^ head[i].dir[DIR_W-1];
      end
   end

   // saturation check, then one restoring quotient bit per stage
   always_comb begin
      logic [DIV_W-1:0] dsh;
      dv_in[0] = a_ff;
      for (int i = 0; i < AXES; i++) begin
         dsh = DIV_W'(a_ff[i].dmag) << Q_W;
         for (int b = 0; b < 2; b++) begin
            dv_in[0][i].sat[b] = (a_ff[i].rem[b] >= dsh);
         end
      end
      for (int s = 0; s < Q_W; s++) begin
         dv_in[s+1] = dv_ff[s];
         for (int i = 0; i < AXES; i++) begin
            dsh = DIV_W'(dv_ff[s][i].dmag) << (Q_W - 1 - s);
            for (int b = 0; b < 2; b++) begin
               if (dv_ff[s][i].rem[b] >= dsh) begin
                  dv_in[s+1][i].rem[b]            = dv_ff[s][i].rem[b] - dsh;
                  dv_in[s+1][i].quo[b][Q_W-1-s]   = 1'b1;
               end
            end
         end
      end
   end

   // signed slab interval per axis, ordered low then high
   always_comb begin
      logic [Q_W:0]          mag;
      logic signed [T_W-1:0] tv [2];
      t_ok_in = 1'b1;
      for (int i = 0; i < AXES; i++) begin
         for (int b = 0; b < 2; b++) begin
            mag   = dv_ff[Q_W][i].sat[b] ? ((Q_W+1)'(1) << Q_W)
                                         : {1'b0, dv_ff[Q_W][i].quo[b]};
            tv[b] = dv_ff[Q_W][i].qneg[b] ? -$signed(T_W'(mag))
                                          : $signed(T_W'(mag));
         end
         if (dv_ff[Q_W][i].par) begin
            tlo_in[i] = -$signed(T_W'(1) << Q_W);
            thi_in[i] = $signed(T_W'(1) << Q_W);
            t_ok_in   = t_ok_in && dv_ff[Q_W][i].in_slab;
         end else if (tv[0] > tv[1]) begin
            tlo_in[i] = tv[1];
            thi_in[i] = tv[0];
         end else begin
            tlo_in[i] = tv[0];
            thi_in[i] = tv[1];
         end
      end
   end

   // clip to the unit interval and merge the three slabs
   always_comb begin
      logic signed [T_W-1:0] tmn, tmx;
      tmn = '0;
      tmx = $signed(T_W'(1) << COORD_FRAC_BITS);
      for (int i = 0; i < AXES; i++) begin
         if (tlo_ff[i] > tmn) tmn = tlo_ff[i];
         if (thi_ff[i] < tmx) tmx = thi_ff[i];
      end
      c_hit_in = t_ok_ff && (tmn <= tmx);
      tmin_in  = tmn[Q_W-1:0];
   end

   // entry point, offset floor-shifted back to coordinate scale
   always_comb begin
      logic signed [PROD_W-1:0]  off;
      logic signed [COORD_W-1:0] pt [AXES];
      for (int i = 0; i < AXES; i++) begin
         off   = prod_ff[i] >>> COORD_FRAC_BITS;
         pt[i] = m_hit_ff ? m_start_ff[i] + off[COORD_W-1:0] : m_start_ff[i];
      end
      rsp_in.hit     = m_hit_ff;
      rsp_in.point_x = pt[0];
      rsp_in.point_y = pt[1];
      rsp_in.point_z = pt[2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
         for (int s = 0; s <= Q_W; s++) begin
            dv_ff[s] <= dv_in[s];
         end
         for (int i = 0; i < AXES; i++) begin
            tlo_ff[i]     <= tlo_in[i];
            thi_ff[i]     <= thi_in[i];
            t_start_ff[i] <= dv_ff[Q_W][i].start;
            t_dir_ff[i]   <= dv_ff[Q_W][i].dir;
            c_start_ff[i] <= t_start_ff[i];
            c_dir_ff[i]   <= t_dir_ff[i];
            prod_ff[i]    <= PROD_W'(c_dir_ff[i]) * $signed({1'b0, tmin_ff});
            m_start_ff[i] <= c_start_ff[i];
         end
         t_ok_ff  <= t_ok_in;
         tmin_ff  <= tmin_in;
         c_hit_ff <= c_hit_in;
         m_hit_ff <= c_hit_ff;
         rsp_ff   <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff   <= 1'b0;
         for (int s = 0; s <= Q_W; s++) begin
            dv_v_ff[s] <= 1'b0;
         end
         t_v_ff   <= 1'b0;
         c_v_ff   <= 1'b0;
         m_v_ff   <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff     <= !qstat.empty;
         dv_v_ff[0] <= a_v_ff;
         for (int s = 0; s < Q_W; s++) begin
            dv_v_ff[s+1] <= dv_v_ff[s];
         end
         t_v_ff   <= dv_v_ff[Q_W];
         c_v_ff   <= t_v_ff;
         m_v_ff   <= c_v_ff;
         rsp_v_ff <= m_v_ff;
      end
   end

endmodule

@@ tb/sv/sbsi_checker.sv @@
// checker: watches segment and result transfers, predicts hit and entry point, compares
module sbsi_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  sbsi_pkg::req_type            req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  sbsi_pkg::rsp_type            rsp_data,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [sbsi_pkg::IDX_W-1:0]   csr_index,
   input  logic [sbsi_pkg::COORD_W-1:0] csr_data,
   output int                           fail_count,
   output int                           pending
);
   import sbsi_pkg::*;

   longint box_center[3];
   longint box_size[3];
   rsp_type expected_points[$];

   function automatic longint floor_frac(longint p);
      longint one;
      one = longint'(1) << COORD_FRAC_BITS;
      if (p >= 0) return p / one;
      return -((-p + one - 1) / one);
   endfunction

   function automatic rsp_type slab_hit(req_type r);
      longint one, tmin, tmax, lo, hi, t1, t2, tt, p;
      longint start[3], dir[3];
      bit hit;
      rsp_type res;
      one = longint'(1) << COORD_FRAC_BITS;
      tmin = 0;
      tmax = one;
      hit = 1;
      start[0] = longint'(r.start_x);
      start[1] = longint'(r.start_y);
      start[2] = longint'(r.start_z);
      dir[0] = longint'(r.end_x) - start[0];
      dir[1] = longint'(r.end_y) - start[1];
      dir[2] = longint'(r.end_z) - start[2];
      for (int i = 0; i < 3; i++) begin
         if (hit) begin
            lo = box_center[i] - box_size[i] / 2;
            hi = box_center[i] + box_size[i] / 2;
            if (dir[i] == 0) begin
               if (start[i] < lo || start[i] > hi) hit = 0;
            end else begin
               t1 = ((lo - start[i]) * one) / dir[i];
               t2 = ((hi - start[i]) * one) / dir[i];
               if (t1 > t2) begin
                  tt = t1; t1 = t2; t2 = tt;
               end
               if (t1 > tmin) tmin = t1;
               if (t2 < tmax) tmax = t2;
               if (tmin > tmax) hit = 0;
            end
         end
      end
      res.hit = hit;
      p = hit ? start[0] + floor_frac(dir[0] * tmin) : start[0];
      res.point_x = p[31:0];
      p = hit ? start[1] + floor_frac(dir[1] * tmin) : start[1];
      res.point_y = p[31:0];
      p = hit ? start[2] + floor_frac(dir[2] * tmin) : start[2];
      res.point_z = p[31:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (box_center[i]) begin
            box_center[i] = 0;
            box_size[i] = 0;
         end
         expected_points.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_CENTER_X: box_center[0] = longint'($signed(csr_data));
               REG_CENTER_Y: box_center[1] = longint'($signed(csr_data));
               REG_CENTER_Z: box_center[2] = longint'($signed(csr_data));
               REG_SIZE_X:   box_size[0] = longint'(csr_data[30:0]);
               REG_SIZE_Y:   box_size[1] = longint'(csr_data[30:0]);
               REG_SIZE_Z:   box_size[2] = longint'(csr_data[30:0]);
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_points.pop_front();
               if (want !== rsp_data) begin
                  if (fail_count < 10)
                     $display({"mismatch: expected hit=%0d pt=(%0d,%0d,%0d)",
                               " got hit=%0d pt=(%0d,%0d,%0d)"},
                        want.hit, want.point_x, want.point_y, want.point_z, rsp_data.hit,
                        rsp_data.point_x, rsp_data.point_y, rsp_data.point_z);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) expected_points.push_back(slab_hit(req_data));
         pending <= expected_points.size();
      end
   end
endmodule

@@ tb/sv/tb_top.sv @@
// testbench top: segment stimulus, box settings, result stalls and the verdict
module tb_top;
   import sbsi_pkg::*;

   localparam int WATCHDOG = 20000;
   localparam int DRAIN    = 40;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [IDX_W-1:0] csr_index = '0;
   logic [COORD_W-1:0] csr_data = '0;
   int fail_count;
   int pending;
   int idle_cycles = 0;
   bit calm = 0;       // no idling on either side while set

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   segment_box_slab_intersection uut (.*);

   sbsi_checker checker_i (.*);

   // watchdog: cycles with no transfer of any kind
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result side stalls about a third of the time
   always @(posedge clock) rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 35);

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [COORD_W-1:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   // wait for every expected result, then let the pipe empty
   task automatic settle();
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic set_box(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                          logic [30:0] sx, logic [30:0] sy, logic [30:0] sz);
      settle();
      write_reg(REG_CENTER_X, cx);
      write_reg(REG_CENTER_Y, cy);
      write_reg(REG_CENTER_Z, cz);
      write_reg(REG_SIZE_X, {1'b0, sx});
      write_reg(REG_SIZE_Y, {1'b0, sy});
      write_reg(REG_SIZE_Z, {1'b0, sz});
      write_reg(3'd7, $urandom);   // unused index, must be ignored
      @(posedge clock);
   endtask

   // one segment transfer, with an optional idle gap first
   task automatic send_segment(req_type seg);
      if (!calm) begin
         while ($urandom_range(99) < 35) begin
            req_valid <= 0;
            @(posedge clock);
         end
      end
      req_valid <= 1;
      req_data  <= seg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic pause_input();
      req_valid <= 0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] near_coord(logic [31:0] c, logic [31:0] span);
      case ($urandom_range(3))
         0: return $urandom;
         1: return c + $signed($urandom_range(2 * span)) - $signed(span);
         2: return c + ($signed($urandom) >>> $urandom_range(31));
         default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      endcase
   endfunction

   // random segment aimed at the current box most of the time
   function automatic req_type rand_segment(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                            logic [31:0] span);
      req_type s;
      s.start_x = near_coord(cx, span);
      s.start_y = near_coord(cy, span);
      s.start_z = near_coord(cz, span);
      s.end_x = near_coord(cx, span);
      s.end_y = near_coord(cy, span);
      s.end_z = near_coord(cz, span);
      // parallel axes and degenerate segments
      if ($urandom_range(9) == 0) s.end_x = s.start_x;
      if ($urandom_range(9) == 0) s.end_y = s.start_y;
      if ($urandom_range(9) == 0) s.end_z = s.start_z;
      return s;
   endfunction

   initial begin
      logic [31:0] cx, cy, cz, span;
      logic [30:0] sz;
      req_type s;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: unit box at origin
      set_box(0, 0, 0, 31'h2_0000, 31'h2_0000, 31'h2_0000);
      send_segment('{32'hfffd_0000, 0, 0, 32'h3_0000, 0, 0});          // through the middle
      send_segment('{0, 0, 0, 32'h1_8000, 32'h0_4000, 0});             // start inside
      send_segment('{32'hfffe_0000, 32'h1_0000, 0, 32'h2_0000, 32'h1_0000, 0}); // grazing face
      send_segment('{32'hfffe_0000, 32'h1_0001, 0, 32'h2_0000, 32'h1_0001, 0}); // just outside
      send_segment('{32'h0_8000, 32'h0_8000, 32'h0_8000,
                     32'h0_8000, 32'h0_8000, 32'h0_8000});             // degenerate inside
      send_segment('{32'h5_0000, 0, 0, 32'h5_0000, 0, 0});             // degenerate outside
      send_segment('{32'hfffa_0000, 32'hfffa_0000, 32'hfffa_0000,
                     32'hfffe_0000, 32'hfffe_0000, 32'hfffe_0000});    // falls short
      send_segment('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});    // full-range diagonal
      send_segment('{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                     32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
      send_segment('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0});
      pause_input();

      // directed: zero-size box and extreme boxes
      set_box(32'h1_0000, 32'h1_0000, 32'h1_0000, 0, 0, 0);
      send_segment('{0, 0, 0, 32'h2_0000, 32'h2_0000, 32'h2_0000});   // through the point
      send_segment('{32'h1_0000, 32'h1_0000, 32'h1_0000,
                     32'h1_0000, 32'h1_0000, 32'h1_0000});
      send_segment('{0, 0, 0, 32'h2_0000, 32'h2_0001, 32'h2_0000});
      pause_input();
      set_box(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
      send_segment('{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                     32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
      send_segment('{0, 0, 0, 0, 0, 0});
      send_segment('{32'h4000_0000, 32'hc000_0000, 32'h4000_0000,
                     32'h4000_0000, 32'hc000_0000, 32'h7000_0000});
      pause_input();
      set_box(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              31'h7fff_ffff, 31'h1, 31'h7fff_ffff);
      send_segment('{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                     32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
      send_segment('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
      pause_input();

      // random phases with a new box each time
      for (int ph = 0; ph < 11; ph++) begin
         cx = $urandom_range(3) == 0 ? $urandom : ($signed($urandom) >>> 8);
         cy = $urandom_range(3) == 0 ? $urandom : ($signed($urandom) >>> 8);
         cz = $urandom_range(3) == 0 ? $urandom : ($signed($urandom) >>> 8);
         sz = $urandom_range(4) == 0 ? 31'($urandom) : 31'($urandom_range(32'h40_0000));
         set_box(cx, cy, cz, sz, $urandom_range(4) == 0 ? 31'($urandom) : sz,
                 $urandom_range(4) == 0 ? 31'($urandom) : sz >> $urandom_range(3));
         span = {1'b0, sz} + 32'h1_0000;
         calm = (ph == 4);   // one long stretch with no idling
         for (int n = 0; n < 100; n++) begin
            s = rand_segment(cx, cy, cz, span);
            send_segment(s);
            // sender holds off until every result has come
            if (n == 50 && ph == 2) begin
               pause_input();
               while (pending != 0) @(posedge clock);
            end
         end
         calm = 0;
         pause_input();
      end

      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
